// File: hdl/shabs_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// Holds the round constant table, the initial hash values and the core control struct.
// No dependencies.
`default_nettype none
package shabs_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NWords = 8;
  localparam int unsigned NWin   = 16;
  localparam int unsigned PosW   = 6;
  localparam int unsigned RndW   = 6;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CntW   = 64;

  localparam logic [7:0] PadMark  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam logic [WordW-1:0] InitHash [NWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       shift;
    logic [7:0] data;
    logic       start;
    logic       init;
  } core_ctrl_t;

  function automatic logic [WordW-1:0] round_k(input logic [RndW-1:0] t);
    logic [WordW-1:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage
`default_nettype wire

// File: hdl/shabs_core.sv
// SHA-256 compression core: message window, one round per cycle, chaining value.
// Depends on shabs_pkg.
`default_nettype none
module shabs_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire shabs_pkg::core_ctrl_t     ctrl_i,
  input  wire logic [shabs_pkg::IdxW-1:0] sel_i,
  output logic [shabs_pkg::WordW-1:0]    word_o,
  output logic                           done_o
);
  import shabs_pkg::*;

  logic [WordW-1:0] win_q   [NWin];
  logic [WordW-1:0] win_d   [NWin];
  logic [WordW-1:0] chain_q [NWords];
  logic [WordW-1:0] v_q     [NWords];
  logic [RndW-1:0]  rnd_q;
  logic             busy_q, add_q;
  logic [WordW-1:0] t1, t2, s0, s1, new_w;

  // Bytes enter at the tail, so the oldest word always sits at the head.
  always_comb begin
    s0    = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1    = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    new_w = s1 + win_q[9] + s0 + win_q[0];
    for (int i = 0; i < NWin; i++) begin
      win_d[i] = win_q[i];
    end
    if (ctrl_i.shift) begin
      for (int i = 0; i < NWin - 1; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[NWin-1] = {win_q[NWin-1][23:0], ctrl_i.data};
    end else if (busy_q) begin
      for (int i = 0; i < NWin - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[NWin-1] = new_w;
    end
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + win_q[0];
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NWin; i++) begin
      win_q[i] <= win_d[i];
    end
    if (ctrl_i.start) begin
      for (int i = 0; i < NWords; i++) begin
        v_q[i] <= chain_q[i];
      end
    end else if (busy_q) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < NWords; i++) begin
        chain_q[i] <= InitHash[i];
      end
    end else begin
      add_q <= busy_q && (rnd_q == RndW'(63));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 1'b1;
        if (rnd_q == RndW'(63)) begin
          busy_q <= 1'b0;
        end
      end
      if (ctrl_i.init) begin
        for (int i = 0; i < NWords; i++) begin
          chain_q[i] <= InitHash[i];
        end
      end else if (add_q) begin
        for (int i = 0; i < NWords; i++) begin
          chain_q[i] <= chain_q[i] + v_q[i];
        end
      end
    end
  end

  assign word_o = chain_q[sel_i];
  assign done_o = add_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q && !add_q) else $error("core started while busy");
  a_last_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && rnd_q == RndW'(63)) |=> add_q && !busy_q) else $error("missing final add");
  a_no_shift_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !ctrl_i.shift) else $error("window written during rounds");

endmodule
`default_nettype wire

// File: hdl/sha256_byte_stream_hasher_unit.sv
// SHA-256 byte stream hasher, top level: byte sequencer, padding, length count, digest output.
// Depends on shabs_pkg and shabs_core.
//
// Usage: each input item is either an absorb (op_i = 0) carrying one message byte, or a
// finish (op_i = 1). Items are taken when in_valid_i is high and in_stall_o is low.
// An absorb needs no stall, except the byte that fills a 64-byte block, after which the
// unit is stalled while the shared round unit runs 64 rounds, one a cycle,
// and adds the result into the chaining value.
// A finish with n bytes pending feeds 64 - n padding bytes at one a cycle, runs one
// compression and, when n is 56 or more, a further 64 bytes and compression.
// The digest then leaves as eight items on the output channel, most significant word
// first, word_index_o counting 0 to 7 and last_word_o set on the eighth.
// A stalled output item holds steady; input stays stalled until the last word is taken,
// after which the unit is ready for a new message.
// Reset loads the standard initial hash values and clears the byte and bit counts.
`default_nettype none
module sha256_byte_stream_hasher_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  message_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import shabs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] bits_q, bits_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            fin_q, fin_d, mark_q, mark_d, lenblk_q, lenblk_d;
  core_ctrl_t      ctrl;
  logic            done;
  logic [WordW-1:0] word;
  logic [7:0]      pad_byte;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    if (!mark_q) begin
      pad_byte = PadMark;
    end else if (lenblk_q && pos_q >= LenStart) begin
      pad_byte = bits_q[{~pos_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    bits_d   = bits_q;
    idx_d    = idx_q;
    fin_d    = fin_q;
    mark_d   = mark_q;
    lenblk_d = lenblk_q;
    ctrl     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!op_i) begin
            ctrl.shift = 1'b1;
            ctrl.data  = message_byte_i;
            pos_d      = pos_q + 1'b1;
            bits_d     = bits_q + CntW'(8);
            fin_d      = 1'b0;
            if (pos_q == PosW'(63)) begin
              ctrl.start = 1'b1;
              state_d    = ST_COMP;
            end
          end else begin
            fin_d    = 1'b1;
            mark_d   = 1'b0;
            lenblk_d = pos_q < LenStart;
            state_d  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctrl.shift = 1'b1;
        ctrl.data  = pad_byte;
        mark_d     = 1'b1;
        pos_d      = pos_q + 1'b1;
        if (pos_q == PosW'(63)) begin
          ctrl.start = 1'b1;
          state_d    = ST_COMP;
        end
      end
      ST_COMP: begin
        if (done) begin
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (!lenblk_q) begin
            lenblk_d = 1'b1;
            state_d  = ST_PAD;
          end else begin
            idx_d   = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == IdxW'(NWords - 1)) begin
            ctrl.init = 1'b1;
            bits_d    = '0;
            fin_d     = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      bits_q   <= '0;
      idx_q    <= '0;
      fin_q    <= 1'b0;
      mark_q   <= 1'b0;
      lenblk_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      bits_q   <= bits_d;
      idx_q    <= idx_d;
      fin_q    <= fin_d;
      mark_q   <= mark_d;
      lenblk_q <= lenblk_d;
    end
  end

  shabs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .sel_i  (idx_q),
    .word_o (word),
    .done_o (done)
  );

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign digest_word_o = word;
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == IdxW'(NWords - 1));

  a_pad_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD && pos_q == PosW'(63)) |=> state_q == ST_COMP) else $error("pad overrun");
  a_emit_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && state_d == ST_EMIT) |=> idx_q == '0) else $error("bad first index");
  a_done_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> state_q == ST_COMP) else $error("compression finished outside wait");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the SHA-256 byte stream hasher unit.
// Predicts each digest word with its own SHA-256 model and compares every output item.
// Depends on shabs_pkg (initial hash values) and sha256_byte_stream_hasher_unit.
`default_nettype none
module tb_top;
  import shabs_pkg::*;

  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;
  localparam int unsigned LongHold = 400;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [7:0]  message_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_byte_stream_hasher_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .message_byte_i,
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  logic [31:0] hash_state [8];
  logic [7:0]  pend_bytes [64];
  int unsigned pend_count;
  logic [63:0] bit_total;

  digest_item_t digest_q [$];
  int unsigned  errors = 0;
  int unsigned  words_seen = 0;
  int unsigned  digests_sent = 0;
  int unsigned  bytes_sent = 0;
  bit           send_idle_en = 1'b1;
  bit           recv_idle_en = 1'b1;
  int unsigned  hold_cycles = 0;
  int unsigned  hold_req = 0;
  int unsigned  hold_done = 0;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_pending();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {pend_bytes[4*t], pend_bytes[4*t+1], pend_bytes[4*t+2], pend_bytes[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
    pend_count = 0;
    bit_total = '0;
  endtask

  // Updates the predictor for one accepted item; a finish queues eight digest words.
  task automatic predict_hash(logic op, logic [7:0] data);
    digest_item_t d;
    if (op == OpAbsorb) begin
      pend_bytes[pend_count] = data;
      pend_count++;
      if (pend_count == 64) begin
        compress_pending();
        bit_total += 64'd512;
        pend_count = 0;
      end
    end else begin
      bit_total += 64'(pend_count * 8);
      pend_bytes[pend_count] = 8'h80;
      for (int i = pend_count + 1; i < 64; i++) pend_bytes[i] = '0;
      if (pend_count >= 56) begin
        compress_pending();
        for (int i = 0; i < 64; i++) pend_bytes[i] = '0;
      end
      for (int i = 0; i < 8; i++) pend_bytes[56+i] = bit_total[63-8*i -: 8];
      compress_pending();
      for (int i = 0; i < 8; i++) begin
        d.word = hash_state[i];
        d.idx  = 3'(i);
        d.last = (i == 7);
        digest_q.push_back(d);
      end
      restart_message();
    end
  endtask

  // Valid stays high after an accepted item; the next item, an idle gap or a drain
  // replaces it in the same time step, so each signal is assigned once per edge.
  task automatic send_item(logic op, logic [7:0] data);
    int gap;
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    message_byte_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    predict_hash(op, data);
    if (op == OpFinish) digests_sent++;
    else bytes_sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(OpAbsorb, 8'($urandom_range(0, 255)));
    send_item(OpFinish, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_done != hold_req) begin
      hold_done   <= hold_req;
      hold_cycles <= LongHold - 1;
      out_stall_i <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
      hold_cycles <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    digest_item_t exp_d;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, digest_word_o);
        errors++;
      end else begin
        exp_d = digest_q.pop_front();
        if (digest_word_o !== exp_d.word || word_index_o !== exp_d.idx ||
            last_word_o !== exp_d.last) begin
          $display("%0t: mismatch expected word %h idx %0d last %0d, got %h idx %0d last %0d",
                   $time, exp_d.word, exp_d.idx, exp_d.last,
                   digest_word_o, word_index_o, last_word_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OpFinish, 8'hff);                     // empty message
    send_item(OpAbsorb, 8'h00); send_item(OpAbsorb, 8'hff);
    send_item(OpAbsorb, 8'h80); send_item(OpFinish, 8'h00);
    send_message(55);                               // one padding block just fits
    send_message(56);                               // length forces an extra block
    send_message(63);
    send_message(64);                               // exactly one full block
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    hold_req++;                                     // output blocked while the next message waits at the input
    send_message(3);
    send_message(1);
    wait_drained();
  endtask

  task automatic test_random_messages();
    int len;
    int room;
    while (bytes_sent + digests_sent < 410) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 20);
      room = 409 - int'(bytes_sent + digests_sent);
      if (len > room) len = room;
      send_message(len);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  task automatic test_no_idle();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    send_message(10);
    send_message(0);
  endtask

  initial begin
    restart_message();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_backpressure();
    test_random_messages();
    test_no_idle();
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d bytes in %0d messages; %0d digest words checked.",
             bytes_sent, digests_sent, words_seen);
    if (errors == 0 && digest_q.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
hdl/shabs_pkg.sv
hdl/shabs_core.sv
hdl/sha256_byte_stream_hasher_unit.sv
verif/tb_top.sv
